// ===== rtl/msr_pkg.sv =====
package msr_pkg;

  localparam int SPEED_W = 8;
  localparam int MAG_W   = 7;
  localparam int WIDE_W  = 10;

  localparam logic signed [WIDE_W-1:0] SPEED_MAX = 10'sd100;
  localparam logic signed [WIDE_W-1:0] SPEED_MIN = -10'sd100;

  localparam logic [MAG_W-1:0] ACCEL_STEP_RST = 7'd10;
  localparam logic [MAG_W-1:0] BRAKE_STEP_RST = 7'd20;
  localparam logic [MAG_W-1:0] MIN_SPEED_RST  = 7'd0;

  typedef enum logic [1:0] {
    KIND_SET_TARGET  = 2'd0,
    KIND_TICK        = 2'd1,
    KIND_STOP        = 2'd2,
    KIND_SET_CURRENT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ACCEL_STEP = 2'd0,
    REG_BRAKE_STEP = 2'd1,
    REG_MIN_SPEED  = 2'd2,
    REG_INVERT     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MAG_W-1:0] accel_step;
    logic [MAG_W-1:0] brake_step;
    logic [MAG_W-1:0] min_speed;
    logic             invert;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] cur;
    logic signed [SPEED_W-1:0] tgt;
    logic                      changed;
  } step_res_t;

  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v < SPEED_MIN) r = SPEED_MIN;
    else if (v > SPEED_MAX) r = SPEED_MAX;
    else r = v;
    return r[SPEED_W-1:0];
  endfunction

endpackage

// ===== rtl/msr_step.sv =====
module msr_step
  import msr_pkg::*;
(
  input  cfg_t                      cfg,
  input  logic [1:0]                kind,
  input  logic signed [SPEED_W-1:0] speed,
  input  logic signed [SPEED_W-1:0] cur,
  input  logic signed [SPEED_W-1:0] tgt,
  output step_res_t                 res
);

  logic signed [WIDE_W-1:0] cur_w, tgt_w, spd_w, cur_mag, tgt_mag;
  logic signed [WIDE_W-1:0] step_w, min_w, nxt, nxt_mag;
  logic                     acc, opposite;
  logic signed [SPEED_W-1:0] tick_val;

  always_comb begin
    cur_w   = WIDE_W'(cur);
    tgt_w   = WIDE_W'(tgt);
    spd_w   = WIDE_W'(speed);
    cur_mag = (cur_w < 0) ? -cur_w : cur_w;
    tgt_mag = (tgt_w < 0) ? -tgt_w : tgt_w;
    min_w   = signed'({3'b000, cfg.min_speed});

    opposite = (cur_w < 0 && tgt_w > 0) || (cur_w > 0 && tgt_w < 0);
    acc      = (cur_w != tgt_w) && !opposite && (tgt_mag > cur_mag);
    step_w   = signed'({3'b000, acc ? cfg.accel_step : cfg.brake_step});

    nxt     = (tgt_w > cur_w) ? cur_w + step_w : cur_w - step_w;
    nxt_mag = (nxt < 0) ? -nxt : nxt;

    // priority: brake past zero, overshoot, minimum-speed floor, plain step
    if (!acc && step_w > cur_mag) begin
      tick_val = '0;
    end else if ((nxt > tgt_w && nxt > cur_w) || (nxt < tgt_w && nxt < cur_w)) begin
      tick_val = tgt;
    end else if (nxt_mag < min_w) begin
      if (acc) tick_val = sat_speed((nxt >= 0) ? min_w : -min_w);
      else tick_val = '0;
    end else begin
      tick_val = sat_speed(nxt);
    end

    res.cur     = cur;
    res.tgt     = tgt;
    res.changed = 1'b0;
    unique case (kind_t'(kind))
      KIND_SET_TARGET: begin
        res.tgt = sat_speed(cfg.invert ? -spd_w : spd_w);
      end
      KIND_TICK: begin
        if (cur_w != tgt_w) begin
          res.cur     = tick_val;
          res.changed = 1'b1;
        end
      end
      KIND_STOP: begin
        res.cur = '0;
      end
      KIND_SET_CURRENT: begin
        res.cur = sat_speed(spd_w);
      end
      default: begin
        res.cur = cur;
      end
    endcase
  end

endmodule

// ===== rtl/motor_speed_ramp.sv =====
// Speed ramp for one motor channel. Items enter on s_axis: tuser is the command
// kind (set target, tick, emergency stop, set current) and tdata the signed
// percent speed. Each item yields one result on m_axis with the current speed
// after it, a changed flag for ticks that moved, the direction and magnitude.
// The block takes one item per cycle unless m_axis back-pressure stalls it: an
// item is held in an input register, then the ramp step (compares and one add)
// updates the speed state and loads the result register in the same cycle. The
// result passes through the input register and the result register before it
// is valid on m_axis. The user must write configuration through the cfg port only
// while no item is in flight; the block does not enforce this. cfg is always ready.
module motor_speed_ramp
  import msr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] speed
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] current_speed, [8] changed, [9] forward,
                                      // [16:10] magnitude, [23:17] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  cfg_t                      cfg;
  logic                      in_valid;
  logic [1:0]                in_kind;
  logic signed [SPEED_W-1:0] in_speed;
  logic signed [SPEED_W-1:0] cur_speed, tgt_speed;
  logic                      advance;
  step_res_t                 res;
  logic signed [SPEED_W-1:0] out_speed;
  logic                      out_changed;
  logic [MAG_W-1:0]          out_mag;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_step <= ACCEL_STEP_RST;
      cfg.brake_step <= BRAKE_STEP_RST;
      cfg.min_speed  <= MIN_SPEED_RST;
      cfg.invert     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ACCEL_STEP: cfg.accel_step <= cfg_data;
        REG_BRAKE_STEP: cfg.brake_step <= cfg_data;
        REG_MIN_SPEED:  cfg.min_speed  <= cfg_data;
        REG_INVERT:     cfg.invert     <= cfg_data[0];
        default:        cfg.invert     <= cfg.invert;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind  <= s_axis_tuser;
      in_speed <= s_axis_tdata;
    end
  end

  msr_step u_step (
    .cfg   (cfg),
    .kind  (in_kind),
    .speed (in_speed),
    .cur   (cur_speed),
    .tgt   (tgt_speed),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_speed     <= '0;
      tgt_speed     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        cur_speed <= res.cur;
        tgt_speed <= res.tgt;
      end
      if (advance) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_speed   <= res.cur;
      out_changed <= res.changed;
      out_mag     <= res.cur[SPEED_W-1] ? MAG_W'(-res.cur) : res.cur[MAG_W-1:0];
    end
  end

  assign m_axis_tdata = {7'b0, out_mag, !out_speed[SPEED_W-1], out_changed, out_speed};

endmodule
